/* sv/rational_reduce_and_add_core_assert.svh */
// Assertion macros used by the port-level checker file.
`ifndef RATIONAL_REDUCE_AND_ADD_CORE_ASSERT_SVH
`define RATIONAL_REDUCE_AND_ADD_CORE_ASSERT_SVH

// Implication checked at every rising clock edge, skipped while in reset.
`define RRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, skipped while in reset.
`define RRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/rra_pkg.sv */
// ----------------------------------------------------------------------------
// rra_pkg
// Types and constants shared by the fraction reduce/add core.
// ----------------------------------------------------------------------------
package rra_pkg;
  localparam int unsigned WideW = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEQ_MUL_P,
    SEQ_MUL_Q,
    SEQ_MUL_D
  } mul_sel_t;

  // start/done strobe pair for a multi-cycle unit
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;
endpackage

/* sv/rra_mul.sv */
// ----------------------------------------------------------------------------
// rra_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rra_mul #(
  parameter int unsigned W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [W-1:0]          a,
  input  logic [W-1:0]          b,
  output logic                  done,
  output logic [2*W-1:0]        prod
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [2*W-1:0] acc_r, acc_nxt;
  logic [2*W-1:0] mcand_r, mcand_nxt;
  logic [W-1:0]   mplier_r, mplier_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = {{W{1'b0}}, a};
      mplier_nxt = b;
      cnt_nxt    = CW'(W);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

/* sv/rra_div.sv */
// ----------------------------------------------------------------------------
// rra_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rra_div #(
  parameter int unsigned W = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  output logic          done,
  output logic [W-1:0]  quot,
  output logic [W-1:0]  rem
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r, q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule

/* sv/rational_reduce_and_add_core.sv */
// ----------------------------------------------------------------------------
// rational_reduce_and_add_core
// Reduces one signed fraction or adds two, result always in lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one beat carries operation (0 reduce, 1 add) and
//   two fractions; operands are the low OPERAND_WIDTH bits, sign-extended.
//   Output channel out_*: one beat per input beat with the reduced fraction
//   (denominator positive, zero as 0/1) and an error flag.
//   Add first runs 3 serial multiplies; the GCD then runs one serial
//   division per Euclid step (data dependent, longest for Fibonacci-like
//   operands), then two divisions by the GCD. Run time is data dependent
//   and set mostly by the shared bit-serial divider. Zero denominators
//   and a zero reduce numerator skip the units and go straight to the
//   result; a zero sum or an overflow ends right after the multiplies.
//   One item at a time: in_ready is high only when idle with no result held.
//   The result sits in an output register; if the receiver stalls it holds
//   there and no new beat is taken until it is delivered.
//   Reset (rst_n low, synchronous) drops any item in flight and out_valid.
// ----------------------------------------------------------------------------
module rational_reduce_and_add_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic signed [31:0]  in_first_num,
  input  logic signed [31:0]  in_first_den,
  input  logic signed [31:0]  in_second_num,
  input  logic signed [31:0]  in_second_den,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  out_result_num,
  output logic [62:0]         out_result_den,
  output logic                out_error
);
  localparam int unsigned W = OPERAND_WIDTH;
  localparam int unsigned WW = rra_pkg::WideW;

  rra_pkg::state_t   st_r, st_nxt;
  rra_pkg::mul_sel_t msel_r, msel_nxt;

  // operand magnitudes and signs
  logic [W-1:0] n1m_r, d1m_r, n2m_r, d2m_r;
  logic         n1s_r, d1s_r, n2s_r, d2s_r;
  logic [WW-1:0] p_r, q_r;                  // magnitudes of cross products
  logic [WW-1:0] nm_r, dm_r;                // final magnitudes
  logic          neg_r;
  logic [WW-1:0] ga_r, gb_r;                // Euclid pair
  logic [WW-1:0] g_r;
  logic [WW-1:0] qn_r;

  logic                  oval_r;
  logic signed [WW-1:0]  onum_r;
  logic [62:0]           oden_r;
  logic                  oerr_r;

  rra_pkg::unit_ctl_t mctl, dctl;
  logic [W-1:0]  ma, mb;
  logic [2*W-1:0] mprod;
  logic [WW-1:0] da, db, dq, dr;

  logic [W-1:0] n1m, d1m, n2m, d2m;
  logic signed [W-1:0] n1w, d1w, n2w, d2w;
  logic take;

  // unit start strobes
  logic gbusy_r, gbusy_nxt;     // a Euclid division is in flight
  logic dstart_r, dstart_nxt;   // division to launch next cycle
  logic mstart_r, mstart_nxt;

  // the operands stay put while a Euclid division runs
  logic [WW-1:0] gsel_big, gsel_small;
  assign gsel_big   = (ga_r > gb_r) ? ga_r : gb_r;
  assign gsel_small = (ga_r > gb_r) ? gb_r : ga_r;

  assign n1w = in_first_num[W-1:0];
  assign d1w = in_first_den[W-1:0];
  assign n2w = in_second_num[W-1:0];
  assign d2w = in_second_den[W-1:0];
  assign n1m = n1w[W-1] ? (~n1w + W'(1)) : n1w;
  assign d1m = d1w[W-1] ? (~d1w + W'(1)) : d1w;
  assign n2m = n2w[W-1] ? (~n2w + W'(1)) : n2w;
  assign d2m = d2w[W-1] ? (~d2w + W'(1)) : d2w;

  assign in_ready = (st_r == rra_pkg::ST_IDLE) && !oval_r;
  assign take     = in_valid && in_ready;

  rra_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mctl.start),
    .a(ma), .b(mb), .done(mctl.done), .prod(mprod)
  );

  rra_div #(.W(WW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dctl.start),
    .dividend(da), .divisor(db), .done(dctl.done), .quot(dq), .rem(dr)
  );

  // signed sum of p and q (signs of products), widened by one bit
  logic          ps, qs, ds;
  logic [WW:0]   ssum;
  logic [WW:0]   sp, sq;
  logic [WW-1:0] smag;
  logic          sneg;
  logic [WW-1:0] mprod_w;
  assign mprod_w = WW'(mprod);
  assign ps   = n1s_r ^ d2s_r;
  assign qs   = n2s_r ^ d1s_r;
  assign ds   = d1s_r ^ d2s_r;
  assign sp   = ps ? (~{1'b0, p_r} + (WW+1)'(1)) : {1'b0, p_r};
  assign sq   = qs ? (~{1'b0, q_r} + (WW+1)'(1)) : {1'b0, q_r};
  assign ssum = sp + sq;
  assign sneg = ssum[WW];
  assign smag = sneg ? (~ssum[WW-1:0] + WW'(1)) : ssum[WW-1:0];

  // GCD done: one of the Euclid pair is zero
  logic gdone;
  assign gdone = (ga_r == '0) || (gb_r == '0);

  // next state
  always_comb begin
    st_nxt   = st_r;
    msel_nxt = msel_r;
    case (st_r)
      rra_pkg::ST_IDLE: begin
        if (take) begin
          if (d1m == '0 || (in_operation && d2m == '0)) st_nxt = rra_pkg::ST_DONE;
          else if (in_operation) begin
            st_nxt   = rra_pkg::ST_MUL;
            msel_nxt = rra_pkg::SEQ_MUL_P;
          end else if (n1m == '0) st_nxt = rra_pkg::ST_DONE;
          else st_nxt = rra_pkg::ST_GCD;
        end
      end
      rra_pkg::ST_MUL: begin
        if (mctl.done) begin
          case (msel_r)
            rra_pkg::SEQ_MUL_P: msel_nxt = rra_pkg::SEQ_MUL_Q;
            rra_pkg::SEQ_MUL_Q: msel_nxt = rra_pkg::SEQ_MUL_D;
            rra_pkg::SEQ_MUL_D: begin
              // p, q are ready; overflow or zero ends early
              if (!sneg && ssum[WW-1]) st_nxt = rra_pkg::ST_DONE;
              else if (smag == '0) st_nxt = rra_pkg::ST_DONE;
              else st_nxt = rra_pkg::ST_GCD;
            end
            default: msel_nxt = rra_pkg::SEQ_MUL_P;
          endcase
        end
      end
      rra_pkg::ST_GCD: if (gdone && !dctl.done && !gbusy_r) st_nxt = rra_pkg::ST_DIVN;
      rra_pkg::ST_DIVN: if (dctl.done) st_nxt = rra_pkg::ST_DIVD;
      rra_pkg::ST_DIVD: if (dctl.done) st_nxt = rra_pkg::ST_DONE;
      rra_pkg::ST_DONE: st_nxt = rra_pkg::ST_IDLE;
      default: st_nxt = rra_pkg::ST_IDLE;
    endcase
  end

  // unit start strobes
  always_comb begin
    mstart_nxt = 1'b0;
    dstart_nxt = 1'b0;
    if (st_r == rra_pkg::ST_IDLE && take && in_operation && d1m != '0 && d2m != '0)
      mstart_nxt = 1'b1;
    if (st_r == rra_pkg::ST_MUL && mctl.done && msel_r != rra_pkg::SEQ_MUL_D)
      mstart_nxt = 1'b1;
    if (st_r == rra_pkg::ST_GCD && gdone && !gbusy_r) dstart_nxt = 1'b1;
    if (st_r == rra_pkg::ST_DIVN && dctl.done) dstart_nxt = 1'b1;
  end

  // p = n1*d2, q = n2*d1, den = d1*d2
  assign mctl.start = mstart_r;
  assign ma = (msel_r == rra_pkg::SEQ_MUL_Q) ? n2m_r :
              (msel_r == rra_pkg::SEQ_MUL_D) ? d1m_r : n1m_r;
  assign mb = (msel_r == rra_pkg::SEQ_MUL_P) ? d2m_r :
              (msel_r == rra_pkg::SEQ_MUL_Q) ? d1m_r : d2m_r;

  // divider: Euclid step in ST_GCD, then nm/g, dm/g
  logic gstart;
  assign gstart = (st_r == rra_pkg::ST_GCD) && !gdone && !gbusy_r;
  assign dctl.start = gstart || dstart_r;
  assign da = (st_r == rra_pkg::ST_GCD) ? gsel_big :
              (st_r == rra_pkg::ST_DIVD) ? dm_r : nm_r;
  assign db = (st_r == rra_pkg::ST_GCD) ? gsel_small : g_r;

  always_comb begin
    gbusy_nxt = gbusy_r;
    if (gstart) gbusy_nxt = 1'b1;
    else if (dctl.done) gbusy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= rra_pkg::ST_IDLE;
      msel_r   <= rra_pkg::SEQ_MUL_P;
      oval_r   <= 1'b0;
      gbusy_r  <= 1'b0;
      dstart_r <= 1'b0;
      mstart_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      msel_r   <= msel_nxt;
      gbusy_r  <= gbusy_nxt;
      dstart_r <= dstart_nxt;
      mstart_r <= mstart_nxt;
      if (out_valid && out_ready) oval_r <= 1'b0;
      if (st_r == rra_pkg::ST_DONE) oval_r <= 1'b1;
    end

    if (take) begin
      n1m_r <= n1m; d1m_r <= d1m; n2m_r <= n2m; d2m_r <= d2m;
      n1s_r <= n1w[W-1]; d1s_r <= d1w[W-1];
      n2s_r <= n2w[W-1]; d2s_r <= d2w[W-1];
      nm_r  <= WW'(n1m);
      dm_r  <= WW'(d1m);
      ga_r  <= WW'(n1m);
      gb_r  <= WW'(d1m);
      neg_r <= n1w[W-1] ^ d1w[W-1];
      // default outcome: error for zero denominator, else 0/1 clean
      oerr_r <= (d1m == '0) || (in_operation && d2m == '0);
      onum_r <= '0;
      oden_r <= 63'd1;
    end

    if (st_r == rra_pkg::ST_MUL && mctl.done) begin
      case (msel_r)
        rra_pkg::SEQ_MUL_P: p_r <= mprod_w;
        rra_pkg::SEQ_MUL_Q: q_r <= mprod_w;
        rra_pkg::SEQ_MUL_D: begin
          nm_r   <= smag;
          dm_r   <= mprod_w;
          ga_r   <= smag;
          gb_r   <= mprod_w;
          neg_r  <= sneg ^ ds;
          oerr_r <= !sneg && ssum[WW-1];
        end
        default: p_r <= p_r;
      endcase
    end

    if (st_r == rra_pkg::ST_GCD) begin
      if (gdone) g_r <= ga_r | gb_r;
      else if (gbusy_r && dctl.done) begin
        ga_r <= gsel_small;
        gb_r <= dr;
      end
    end

    if (st_r == rra_pkg::ST_DIVN && dctl.done) qn_r <= dq;

    if (st_r == rra_pkg::ST_DIVD && dctl.done) begin
      if (neg_r) begin
        onum_r <= ~qn_r + WW'(1);
        oden_r <= dq[62:0];
      end else if (qn_r[WW-1]) begin
        onum_r <= '0;
        oden_r <= 63'd1;
        oerr_r <= 1'b1;
      end else begin
        onum_r <= qn_r;
        oden_r <= dq[62:0];
      end
    end
  end

  assign out_valid      = oval_r;
  assign out_result_num = onum_r;
  assign out_result_den = oden_r;
  assign out_error      = oerr_r;
endmodule

/* sv/rra_checker.sv */
// ----------------------------------------------------------------------------
// rra_checker
// Port-level checks for the fraction reduce/add core.
// ----------------------------------------------------------------------------
`include "rational_reduce_and_add_core_assert.svh"

module rra_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [63:0]  out_result_num,
  input logic [62:0]  out_result_den,
  input logic         out_error
);
  `RRA_ASSERT_IMP(a_den_pos, clk, rst_n, out_valid, out_result_den != 63'd0)
  `RRA_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_error,
    out_result_num == 64'd0 && out_result_den == 63'd1)
  `RRA_ASSERT_IMP(a_no_take_busy, clk, rst_n, out_valid, !in_ready)
  `RRA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_result_num) && $stable(out_error))
endmodule

bind rational_reduce_and_add_core rra_checker u_rra_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_result_num(out_result_num), .out_result_den(out_result_den),
  .out_error(out_error)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rational_reduce_and_add_core.
// A queue-fed driver sends request beats; a clocked monitor compares every
// result beat field by field against a fraction predictor. The run has four
// phases: no idling, sender idling, receiver stalling, and both.
// ----------------------------------------------------------------------------
module tb;

  // one request beat
  typedef struct {
    logic               op;
    logic signed [31:0] n1;
    logic signed [31:0] d1;
    logic signed [31:0] n2;
    logic signed [31:0] d2;
  } request_t;

  // one reduced fraction
  typedef struct {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic               err;
  } fraction_t;

  localparam logic OP_REDUCE = 1'b0;
  localparam logic OP_ADD    = 1'b1;
  localparam int   NUM_RANDOM = 630;
  // worst Euclid chain plus multiplies and divides, plus stalls,
  // taken many times over for every item
  localparam longint CYCLE_LIMIT = 64'd30_000_000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_operation;
  logic signed [31:0] in_first_num;
  logic signed [31:0] in_first_den;
  logic signed [31:0] in_second_num;
  logic signed [31:0] in_second_den;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_result_num;
  logic [62:0]        out_result_den;
  logic               out_error;

  request_t  pending_reqs[$];   // filled by the stimulus block, drained by driver
  fraction_t expected_fracs[$]; // predicted results, oldest first
  int        send_idle_pct;
  int        recv_stall_pct;
  int        mismatches;
  longint    cycles;

  rational_reduce_and_add_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation),
    .in_first_num(in_first_num), .in_first_den(in_first_den),
    .in_second_num(in_second_num), .in_second_den(in_second_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_num(out_result_num), .out_result_den(out_result_den),
    .out_error(out_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fraction predictor: cross-multiply for add, Euclid GCD, normalize sign.
  function automatic fraction_t reduce_fraction(request_t r);
    fraction_t res;
    longint    a, b, c, d, p, q, num, den;
    bit [63:0] nm, dm, x, y, g;
    bit        neg;
    a = r.n1; b = r.d1; c = r.n2; d = r.d2;
    res.num = 64'sd0;
    res.den = 63'd1;
    res.err = 1'b1;
    if (b == 0) return res;
    if (r.op == OP_REDUCE) begin
      num = a;
      den = b;
    end else begin
      if (d == 0) return res;
      p = a * d;
      q = c * b;
      // sum can only leave the signed range upward
      if (p > 0 && q > 0 && p > 64'sh7FFF_FFFF_FFFF_FFFF - q) return res;
      num = p + q;
      den = b * d;
    end
    res.err = 1'b0;
    if (num == 0) return res;
    nm = (num < 0) ? 64'd0 - 64'(num) : 64'(num);
    dm = (den < 0) ? 64'd0 - 64'(den) : 64'(den);
    x = nm;
    y = dm;
    while (x != 0 && y != 0) begin
      if (x > y) x = x % y;
      else y = y % x;
    end
    g = x + y;
    nm = nm / g;
    dm = dm / g;
    neg = (num < 0) != (den < 0);
    if (!neg && nm[63]) begin
      res.err = 1'b1;
      return res;
    end
    res.num = neg ? 64'd0 - nm : nm;
    res.den = dm[62:0];
    return res;
  endfunction

  function automatic void add_req(logic op, logic signed [31:0] n1, logic signed [31:0] d1,
                                  logic signed [31:0] n2, logic signed [31:0] d2);
    request_t r;
    r.op = op; r.n1 = n1; r.d1 = d1; r.n2 = n2; r.d2 = d2;
    pending_reqs.push_back(r);
  endfunction

  // operand mix: small values with shared factors, full range, edges, powers of two, zero, +-1
  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    int                 sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)      v = $urandom_range(1, 60) * $urandom_range(1, 36);
    else if (sel < 75) v = $urandom;
    else if (sel < 85) v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else if (sel < 92) v = 32'sd1 << $urandom_range(0, 30);
    else if (sel < 96) v = 32'sd0;
    else               v = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
    if (sel < 40 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Driver: a new beat goes out only once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        in_operation  <= r.op;
        in_first_num  <= r.n1;
        in_first_den  <= r.d1;
        in_second_num <= r.n2;
        in_second_den <= r.d2;
        in_valid      <= 1'b1;
        expected_fracs.push_back(reduce_fraction(r));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: sample on the edge, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fracs.size() == 0) begin
          $display("%0t: unexpected result beat num=%0d den=%0d err=%0b",
                   $time, out_result_num, out_result_den, out_error);
          mismatches++;
        end else begin
          fraction_t e;
          e = expected_fracs.pop_front();
          if (out_result_num !== e.num) begin
            $display("%0t: num expected %0d actual %0d", $time, e.num, out_result_num);
            mismatches++;
          end
          if (out_result_den !== e.den) begin
            $display("%0t: den expected %0d actual %0d", $time, e.den, out_result_den);
            mismatches++;
          end
          if (out_error !== e.err) begin
            $display("%0t: error expected %0b actual %0b", $time, e.err, out_error);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 65, 0, 8};
    stall_tab = '{0, 0, 65, 8};
    mismatches     = 0;
    cycles         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    out_ready      = 1'b0;
    in_operation   = OP_REDUCE;
    in_first_num   = '0;
    in_first_den   = '0;
    in_second_num  = '0;
    in_second_den  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges, zero denominators, zero numerator, sign handling
    add_req(OP_REDUCE, 32'sd6, 32'sd4, 32'sd0, 32'sd0);
    add_req(OP_REDUCE, 32'sd6, -32'sd4, 32'sh7FFF_FFFF, 32'sh8000_0000); // second ignored
    add_req(OP_REDUCE, -32'sd6, -32'sd4, -32'sd1, 32'sd0);
    add_req(OP_REDUCE, 32'sd0, -32'sd5, 32'sd3, 32'sd3);              // zero numerator
    add_req(OP_REDUCE, 32'sd7, 32'sd0, 32'sd1, 32'sd1);               // zero denominator
    add_req(OP_REDUCE, 32'sh8000_0000, 32'sh8000_0000, 32'sd0, 32'sd0);
    add_req(OP_REDUCE, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd0);
    add_req(OP_REDUCE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd0);
    add_req(OP_REDUCE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sd0, 32'sd0);
    add_req(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
    add_req(OP_ADD, 32'sd1, 32'sd6, 32'sd1, 32'sd3);                  // unequal dens, reducible
    add_req(OP_ADD, 32'sd1, 32'sd2, -32'sd1, 32'sd2);                 // sums to zero
    add_req(OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1);                  // first den zero
    add_req(OP_ADD, 32'sd1, 32'sd1, 32'sd1, 32'sd0);                  // second den zero
    add_req(OP_ADD, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000);                          // sum overflow
    add_req(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_req(OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh8000_0000, 32'sh7FFF_FFFF);                          // large negative
    add_req(OP_ADD, 32'sh8000_0000, -32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_req(OP_ADD, 32'sh7FFF_FFFF, -32'sd1, 32'sh8000_0000, 32'sh8000_0000);
    add_req(OP_ADD, -32'sd3, 32'sd4, 32'sd5, -32'sd6);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (int i = 0; i < NUM_RANDOM / 4; i++) begin
        add_req(logic'($urandom_range(0, 1)), pick_operand(), pick_operand(),
                pick_operand(), pick_operand());
      end
      while (pending_reqs.size() != 0 || expected_fracs.size() != 0) @(posedge clk);
    end

    // let any trailing beat settle
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
